// ----- rtl/core/signed_int32_divider_assert.svh -----
// Assertion macros for the signed divider control module
`ifndef SIGNED_INT32_DIVIDER_ASSERT_SVH
`define SIGNED_INT32_DIVIDER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define SID_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SID_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/sid_pkg.sv -----
// Shared constants and types for the signed divider
package sid_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    localparam logic [DATA_WIDTH-1:0] MAX_POS  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MIN_NEG  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] MINUS_ONE = {DATA_WIDTH{1'b1}};
    localparam logic [CNT_W-1:0]      LAST_BIT = CNT_W'(DATA_WIDTH - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic last_step;
    } status_t;

endpackage

// ----- rtl/core/sid_ctrl.sv -----
// Sequencing state machine and output valid register for the signed divider
`include "signed_int32_divider_assert.svh"

module sid_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  sid_pkg::status_t status,
    output sid_pkg::cmd_t    cmd
);

    sid_pkg::state_t state_reg;
    sid_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != sid_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sid_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            sid_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sid_pkg::ST_RUN;
                end
            end
            sid_pkg::ST_RUN:
            begin
                cmd.step = 1'b1;
                if (status.last_step)
                begin
                    state_next = sid_pkg::ST_FINISH;
                end
            end
            sid_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sid_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sid_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    `SID_ASSERT_NEXT(a_load_starts_run, clk, rst_n, cmd.load,
        state_reg == sid_pkg::ST_RUN, "load did not start iteration")
    `SID_ASSERT_NEXT(a_run_holds, clk, rst_n,
        (state_reg == sid_pkg::ST_RUN) && !status.last_step,
        state_reg == sid_pkg::ST_RUN, "iteration left early")
    `SID_ASSERT_NEXT(a_emit_shows, clk, rst_n, cmd.emit, out_valid_reg,
        "emitted transaction not presented")

endmodule

// ----- rtl/core/sid_datapath.sv -----
// Magnitude, shift-subtract iteration and sign fix-up datapath for the signed divider
module sid_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sid_pkg::cmd_t                       cmd,
    output sid_pkg::status_t                    status,
    input  logic signed [sid_pkg::DATA_WIDTH-1:0] numerator,
    input  logic signed [sid_pkg::DATA_WIDTH-1:0] denominator,
    output logic signed [sid_pkg::DATA_WIDTH-1:0] quotient
);

    localparam int W = sid_pkg::DATA_WIDTH;

    logic [W-1:0]              acc_reg;
    logic [W-1:0]              acc_next;
    logic [W-1:0]              rem_reg;
    logic [W-1:0]              rem_next;
    logic [W-1:0]              den_reg;
    logic [W-1:0]              den_next;
    logic                      neg_reg;
    logic                      neg_next;
    logic                      special_reg;
    logic                      special_next;
    logic [sid_pkg::CNT_W-1:0] cnt_reg;
    logic [sid_pkg::CNT_W-1:0] cnt_next;
    logic [W-1:0]              quotient_reg;
    logic [W-1:0]              quotient_next;

    logic [W-1:0] num_u;
    logic [W-1:0] den_u;
    logic [W-1:0] rem_shift;
    logic [W:0]   diff;
    logic         fits;

    assign num_u     = numerator;
    assign den_u     = denominator;
    assign rem_shift = {rem_reg[W-2:0], acc_reg[W-1]};
    assign diff      = {1'b0, rem_shift} - {1'b0, den_reg};
    assign fits      = !diff[W];

    assign status.last_step = (cnt_reg == '0);
    assign quotient         = quotient_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        neg_reg      <= neg_next;
        special_reg  <= special_next;
        quotient_reg <= quotient_next;
    end

    always_comb
    begin
        acc_next      = acc_reg;
        rem_next      = rem_reg;
        den_next      = den_reg;
        neg_next      = neg_reg;
        special_next  = special_reg;
        cnt_next      = cnt_reg;
        quotient_next = quotient_reg;
        if (cmd.load)
        begin
            acc_next     = num_u[W-1] ? (W'(0) - num_u) : num_u;
            den_next     = den_u[W-1] ? (W'(0) - den_u) : den_u;
            rem_next     = '0;
            neg_next     = num_u[W-1] ^ den_u[W-1];
            special_next = (den_u == '0)
                || ((num_u == sid_pkg::MIN_NEG) && (den_u == sid_pkg::MINUS_ONE));
            cnt_next     = sid_pkg::LAST_BIT;
        end
        if (cmd.step)
        begin
            rem_next = fits ? diff[W-1:0] : rem_shift;
            acc_next = {acc_reg[W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
        end
        if (cmd.emit)
        begin
            if (special_reg)
            begin
                quotient_next = sid_pkg::MAX_POS;
            end
            else
            begin
                quotient_next = neg_reg ? (W'(0) - acc_reg) : acc_reg;
            end
        end
    end

endmodule

// ----- rtl/core/signed_int32_divider.sv -----
// Top level of the signed 32-bit divider
// Usage:
//   Input channel in_valid/in_stall carries numerator and denominator; a
//   transaction is taken on a clock edge with in_valid high and in_stall low.
//   Output channel out_valid/out_stall carries quotient, truncated toward zero.
//   A zero divisor, and the most negative value divided by minus one, both
//   return the largest positive value.
// Timing:
//   One quotient bit is resolved per cycle by a single shared subtract and
//   compare unit, most significant bit first. A new pair is taken only after
//   the previous quotient has moved into the output register; in_stall stays
//   high until then.
//   The output register frees the input side: a new pair is accepted while
//   the previous quotient still waits to be taken.
// Reset:
//   rst_n is asynchronous and active low; it drops any pair in flight and
//   clears out_valid. If the receiver stalls, the finished quotient waits
//   inside and in_stall stays high until the output register is free.
module signed_int32_divider (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [sid_pkg::DATA_WIDTH-1:0] numerator,
    input  logic signed [sid_pkg::DATA_WIDTH-1:0] denominator,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [sid_pkg::DATA_WIDTH-1:0] quotient
);

    sid_pkg::cmd_t    cmd;
    sid_pkg::status_t status;

    sid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    sid_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .numerator   (numerator),
        .denominator (denominator),
        .quotient    (quotient)
    );

endmodule

// ----- sim/signed_int32_divider_test.sv -----
// Self-checking testbench for the signed 32-bit shift-and-subtract divider
module signed_int32_divider_test;

    typedef logic signed [sid_pkg::DATA_WIDTH-1:0] word_t;

    typedef struct {
        word_t dividend;
        word_t divisor;
        word_t quotient;
    } division_t;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 40;
    localparam int REPORT_LIMIT   = 10;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  in_valid;
    logic  in_stall;
    word_t numerator;
    word_t denominator;
    logic  out_valid;
    logic  out_stall;
    word_t quotient;

    division_t pending_divisions[$];
    int        failures;
    int        idle_cycles;
    int        sender_idle_pct;
    int        receiver_stall_pct;

    signed_int32_divider dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .numerator  (numerator),
        .denominator(denominator),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .quotient   (quotient)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic word_t predict_quotient(input word_t dividend, input word_t divisor);
        longint wide_quotient;
        if (divisor == '0
            || (dividend == sid_pkg::MIN_NEG && divisor == sid_pkg::MINUS_ONE))
            return sid_pkg::MAX_POS;
        wide_quotient = longint'(dividend) / longint'(divisor);
        return word_t'(wide_quotient);
    endfunction

    function automatic word_t random_operand();
        word_t value;
        case ($urandom_range(5))
            0, 1: value = word_t'($urandom);
            2: value = word_t'(int'($urandom_range(64)) - 32);
            3:
            begin
                case ($urandom_range(4))
                    0: value = sid_pkg::MIN_NEG;
                    1: value = sid_pkg::MAX_POS;
                    2: value = sid_pkg::MINUS_ONE;
                    3: value = '0;
                    default: value = word_t'(1);
                endcase
            end
            4:
            begin
                value = word_t'(1) <<< $urandom_range(sid_pkg::DATA_WIDTH - 1);
                if ($urandom_range(1))
                    value = -value;
            end
            default: value = word_t'($urandom) >>> $urandom_range(sid_pkg::DATA_WIDTH - 1);
        endcase
        return value;
    endfunction

    // Record accepted transactions and check results in one process
    always @(posedge clk)
    begin
        division_t head;
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (in_valid && !in_stall)
            begin
                head.dividend = numerator;
                head.divisor  = denominator;
                head.quotient = predict_quotient(numerator, denominator);
                pending_divisions.push_back(head);
            end
            if (out_valid && !out_stall)
            begin
                if (pending_divisions.size() == 0)
                begin
                    failures = failures + 1;
                    if (failures <= REPORT_LIMIT)
                        $display("unexpected quotient %0d", quotient);
                end
                else
                begin
                    head = pending_divisions.pop_front();
                    if (quotient !== head.quotient)
                    begin
                        failures = failures + 1;
                        if (failures <= REPORT_LIMIT)
                            $display("%0d / %0d: expected %0d, got %0d",
                                     head.dividend, head.divisor, head.quotient, quotient);
                    end
                end
            end
        end
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    task automatic send_operands(input word_t dividend, input word_t divisor);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid    = 1'b1;
        numerator   = dividend;
        denominator = divisor;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic wait_for_quotients();
        in_valid = 1'b0;
        while (pending_divisions.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_corner_cases();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_operands(sid_pkg::MIN_NEG, sid_pkg::MINUS_ONE);
        send_operands(sid_pkg::MIN_NEG, word_t'(1));
        send_operands('0, '0);
        send_operands(word_t'(1234), '0);
        send_operands(sid_pkg::MIN_NEG, '0);
        send_operands(sid_pkg::MAX_POS, '0);
        send_operands(sid_pkg::MINUS_ONE, '0);
        send_operands(sid_pkg::MIN_NEG, sid_pkg::MIN_NEG);
        send_operands(sid_pkg::MAX_POS, sid_pkg::MAX_POS);
        send_operands(sid_pkg::MAX_POS, sid_pkg::MIN_NEG);
        send_operands(sid_pkg::MIN_NEG, sid_pkg::MAX_POS);
        send_operands(word_t'(-7), word_t'(2));
        send_operands(word_t'(7), word_t'(-2));
        send_operands(word_t'(-7), word_t'(-2));
        send_operands(word_t'(7), word_t'(2));
        send_operands('0, word_t'(5));
        send_operands('0, sid_pkg::MINUS_ONE);
        send_operands(word_t'(1), sid_pkg::MIN_NEG);
        send_operands(sid_pkg::MAX_POS, word_t'(1));
        send_operands(sid_pkg::MAX_POS, sid_pkg::MINUS_ONE);
        send_operands(sid_pkg::MIN_NEG, word_t'(2));
        send_operands(sid_pkg::MIN_NEG, word_t'(-2));
        send_operands(word_t'(5), word_t'(7));
        send_operands(sid_pkg::MINUS_ONE, sid_pkg::MINUS_ONE);
    endtask

    task automatic test_random_operands(input int count, input int idle_pct,
                                        input int stall_pct);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (count)
            send_operands(random_operand(), random_operand());
    endtask

    task automatic test_drain_pause();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_operands(word_t'($urandom), word_t'($urandom));
        wait_for_quotients();
        @(negedge clk);
        send_operands(word_t'($urandom), word_t'(int'($urandom_range(200)) - 100));
    endtask

    initial
    begin
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        numerator          = '0;
        denominator        = '0;
        out_stall          = 1'b0;
        failures           = 0;
        idle_cycles        = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (4)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_corner_cases();
        test_drain_pause();
        test_random_operands(100, 0, 0);
        test_random_operands(100, 80, 0);
        test_drain_pause();
        test_random_operands(100, 0, 80);
        test_random_operands(100, 13, 13);

        wait_for_quotients();
        repeat (TAIL_CYCLES)
            @(negedge clk);
        if (failures == 0 && pending_divisions.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
